@@ hw/rtl/sbfd_pkg.sv @@
// Package for the seven-bit frame decoder: result kind codes, widths and
// the result record handed from the frame logic to the top level.
// No dependencies.
package sbfd_pkg;

  localparam int LINE_W  = 8;
  localparam int DATA_W  = 8;
  localparam int BITS_W  = 7;  // payload bits per line byte
  localparam int POS_W   = 3;  // pending bit count, 0..7
  localparam int SUM_W   = 7;  // checksum and byte index are mod 128

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // One step's outcome: whether a result exists and its payload
  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [DATA_W-1:0]   data;
  } sbfd_res_t;

endpackage

@@ hw/rtl/sbfd_frame.sv @@
// Frame state and per-byte decode step: bit packing, checksum, frame end.
// Depends on sbfd_pkg.
module sbfd_frame (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [sbfd_pkg::LINE_W-1:0] line_byte,
  output sbfd_pkg::sbfd_res_t         res
);
  import sbfd_pkg::*;

  logic [BITS_W-1:0] partial_r, partial_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  index_r, index_nxt;

  logic [BITS_W-1:0]          bits;
  logic [BITS_W-1:0]          held;
  logic [DATA_W+BITS_W-1:0]   packed_w;
  logic [DATA_W-1:0]          acc;
  logic [SUM_W-1:0]           term;

  // Merge held bits with the new seven at the current bit position
  always_comb begin
    bits     = line_byte[LINE_W-1:1];
    held     = partial_r & BITS_W'((8'(1) << pos_r) - 8'(1));
    packed_w = ({{DATA_W{1'b0}}, bits} << pos_r) | {{DATA_W{1'b0}}, held};
    acc      = packed_w[DATA_W-1:0];
    term     = index_r ^ acc[SUM_W-1:0];
  end

  // Next state and result
  always_comb begin
    partial_nxt = partial_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    index_nxt   = index_r;
    res.valid   = 1'b0;
    res.kind    = KIND_DATA;
    res.data    = '0;
    if (line_byte[0]) begin
      // frame end: compare checksum, drop pending bits
      res.valid = 1'b1;
      res.kind  = (bits == sum_r) ? KIND_GOOD : KIND_BAD;
      pos_nxt   = '0;
      sum_nxt   = '0;
      index_nxt = '0;
    end else if (pos_r == '0) begin
      // first group byte: only stored
      partial_nxt = bits;
      pos_nxt     = POS_W'(BITS_W);
    end else begin
      res.valid   = 1'b1;
      res.data    = acc;
      sum_nxt     = sum_r + term;
      index_nxt   = index_r + SUM_W'(1);
      partial_nxt = packed_w[DATA_W+BITS_W-1:DATA_W];
      pos_nxt     = pos_r - POS_W'(1);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pos_r     <= '0;
      sum_r     <= '0;
      index_r   <= '0;
    end else if (step_en) begin
      partial_r <= partial_nxt;
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      index_r   <= index_nxt;
    end
  end

endmodule

@@ hw/rtl/seven_bit_frame_decoder.sv @@
// Top level of the seven-bit frame decoder: input register, frame logic,
// result register. Depends on sbfd_pkg and sbfd_frame.
//
//   Channel | Ports                              | Direction
//   --------+------------------------------------+----------
//   input   | in_valid, in_ready, in_line_byte   | in
//   result  | out_valid, out_ready, out_kind,    | out
//           | out_data_byte                      |
//
// One line byte per cycle unless the result side stalls: a byte is taken into
// the input register, decoded by one pass of the frame logic, and any result
// lands in the result register. out_valid comes from the result register,
// behind the input register, so a result never leaves at its input transfer.
// Reset (rst_n low, synchronous) empties both registers and clears the frame.
// A stalled result holds the input register; in_ready drops only when both
// registers are full and out_ready is low.
module seven_bit_frame_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sbfd_pkg::LINE_W-1:0]   in_line_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [sbfd_pkg::DATA_W-1:0]   out_data_byte
);
  import sbfd_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [LINE_W-1:0] s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r;
  logic [DATA_W-1:0] out_data_r;

  logic      out_free;
  logic      s1_go;
  logic      in_xfer;
  sbfd_res_t res;

  // Handshake: stage 1 moves whenever the result register can take it
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_go;
  assign in_xfer  = in_valid && in_ready;

  sbfd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_go),
    .line_byte (s1_byte_r),
    .res       (res)
  );

  always_comb begin
    s1_valid_nxt  = in_xfer ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_free ? (s1_go && res.valid) : out_valid_r;
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_line_byte;
    end
    if (s1_go && res.valid) begin
      out_kind_r <= res.kind;
      out_data_r <= res.data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data_byte = out_data_r;

  // Checks
  a_data_zero_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_data_byte == '0)
    else $error("frame end result carries nonzero data");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without result backpressure");

  a_frame_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_byte_r[0] |=> out_valid && out_kind != KIND_DATA)
    else $error("frame end produced no status result");

endmodule

@@ bench/sbfd_checker.sv @@
// Checker for the seven-bit frame decoder: watches both channels, predicts
// each line byte's decoded result and compares it with what the block sends.
// Depends on sbfd_pkg.
module sbfd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [sbfd_pkg::LINE_W-1:0]   in_line_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    out_kind,
  input  logic [sbfd_pkg::DATA_W-1:0]   out_data_byte,
  output int                            fail_count,
  output int                            pending
);
  import sbfd_pkg::*;

  typedef struct {
    kind_t             kind;
    logic [DATA_W-1:0] data;
  } decoded_t;

  // Results still owed by the block, oldest first
  decoded_t expected_decodes[$];

  // Own copy of the frame state
  logic [DATA_W-1:0] partial_bits;
  logic [POS_W-1:0]  bit_pos;
  logic [SUM_W-1:0]  frame_sum;
  logic [SUM_W-1:0]  byte_idx;

  // Advance the frame state by one line byte; say whether a result comes out
  function automatic void decode_line(input logic [LINE_W-1:0] lb,
                                      output logic produced,
                                      output decoded_t res);
    logic [BITS_W-1:0] bits;
    logic [DATA_W-1:0] acc;
    logic [POS_W-1:0]  pos;
    bits     = lb[LINE_W-1:1];
    produced = 1'b0;
    res.kind = KIND_DATA;
    res.data = '0;
    if (lb[0]) begin
      // frame end: checksum compare, then clear position, sum and index
      produced = 1'b1;
      res.kind = (bits == frame_sum) ? KIND_GOOD : KIND_BAD;
      bit_pos   = '0;
      frame_sum = '0;
      byte_idx  = '0;
    end else begin
      pos = bit_pos;
      // stale bits above the pending count are masked off
      acc = (partial_bits & ((8'd1 << pos) - 8'd1)) | (DATA_W'(bits) << pos);
      if (pos != '0) begin
        frame_sum = frame_sum + (byte_idx ^ acc[SUM_W-1:0]);
        byte_idx  = byte_idx + 1'b1;
        produced  = 1'b1;
        res.data  = acc;
        acc = DATA_W'(bits) >> (8 - pos);
      end
      partial_bits = acc;
      bit_pos      = pos + 3'd7;
    end
  endfunction

  always @(posedge clk) begin
    decoded_t want;
    decoded_t guess;
    logic     produced;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      partial_bits = '0;
      bit_pos      = '0;
      frame_sum    = '0;
      byte_idx     = '0;
      expected_decodes.delete();
    end else begin
      // result side first: a result never leaves at the edge its byte enters
      if (out_valid && out_ready) begin
        if (expected_decodes.size() == 0) begin
          $display("%0t: unexpected result: expected none, got kind %0d data %02h",
                   $time, out_kind, out_data_byte);
          errs++;
        end else begin
          want = expected_decodes.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d, got %0d",
                     $time, want.kind, out_kind);
            errs++;
          end
          if (out_data_byte !== want.data) begin
            $display("%0t: data_byte mismatch: expected %02h, got %02h",
                     $time, want.data, out_data_byte);
            errs++;
          end
        end
      end
      // predict on every input transfer
      if (in_valid && in_ready) begin
        decode_line(in_line_byte, produced, guess);
        if (produced) expected_decodes.push_back(guess);
      end
    end
    fail_count <= fail_count + errs;
    pending    <= expected_decodes.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the seven-bit frame decoder: clock, reset, line byte
// stimulus, result-side stalls, watchdog and verdict.
// Depends on sbfd_pkg, seven_bit_frame_decoder and sbfd_checker.
module tb;
  import sbfd_pkg::*;

  localparam int QUIET_LIMIT = 1000;  // cycles with no transfer at all
  localparam int LONG_HOLD   = 150;   // one long result-side hold-off
  localparam int ITEM_TARGET = 850;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [LINE_W-1:0] in_line_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_kind;
  logic [DATA_W-1:0] out_data_byte;

  int fail_count;
  int pending;
  int sent_items = 0;
  int idle_max   = 12;
  int stall_max  = 12;
  int quiet_cycles = 0;
  bit long_hold  = 1'b0;

  seven_bit_frame_decoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_line_byte  (in_line_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte)
  );

  sbfd_checker mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_line_byte  (in_line_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall before each transfer, one long hold on request
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        stall     = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        stall = $urandom_range(0, stall_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one line byte after a random gap; returns at the falling edge
  // after the transfer with valid still high
  task automatic send_byte(input logic [LINE_W-1:0] b);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_line_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  // Encode n data bytes into 7-bit groups, LSB first, and close the frame
  // with the checksum; corrupt flips checksum bits for a bad frame
  task automatic send_frame(input int n, input fill_t fill, input bit corrupt);
    logic [BITS_W-1:0] chunk;
    logic [SUM_W-1:0]  sum;
    logic [DATA_W-1:0] d;
    int                cnt;
    sum = '0;
    cnt = 0;
    chunk = '0;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ONES:  d = 8'hFF;
        FILL_ZEROS: d = 8'h00;
        default:    d = DATA_W'($urandom_range(0, 255));
      endcase
      sum = sum + (SUM_W'(i) ^ d[SUM_W-1:0]);
      for (int b = 0; b < DATA_W; b++) begin
        chunk[cnt] = d[b];
        cnt++;
        if (cnt == BITS_W) begin
          send_byte({chunk, 1'b0});
          cnt = 0;
        end
      end
    end
    // leftover bits go out with random padding and are dropped by the block
    if (cnt > 0) begin
      for (int b = cnt; b < BITS_W; b++) chunk[b] = 1'($urandom_range(0, 1));
      send_byte({chunk, 1'b0});
    end
    if (corrupt) sum = sum ^ SUM_W'($urandom_range(1, 127));
    send_byte({sum, 1'b1});
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  // Sender pause until the block owes nothing
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int sel;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_line_byte = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty frames good and bad, all-ones and all-zeros payload,
    // a frame ending with pending bits
    send_byte(8'h01);
    send_byte(8'hFF);
    send_frame(7, FILL_ONES, 1'b0);
    send_frame(2, FILL_ZEROS, 1'b1);
    send_frame(3, FILL_RANDOM, 1'b0);

    // Back-pressure: long result hold while bytes keep coming, then drain
    go_idle();
    wait_drained();
    idle_max  = 0;
    long_hold = 1'b1;
    send_frame(30, FILL_RANDOM, 1'b0);
    idle_max  = 12;
    go_idle();
    wait_drained();

    // One long frame so the checksum and, past 128 bytes, the index wrap
    send_frame($urandom_range(125, 140), FILL_RANDOM, 1'($urandom_range(0, 1)));

    // Random: mostly well-formed frames, some corrupt, some noise
    while (sent_items < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        idle_max  = 0;
        stall_max = 0;
      end else begin
        idle_max  = 12;
        stall_max = 12;
      end
      sel = $urandom_range(0, 39);
      if (sel == 0) begin
        send_frame($urandom_range(125, 140), FILL_RANDOM, 1'($urandom_range(0, 1)));
      end else if (sel <= 5) begin
        send_frame($urandom_range(0, 16), FILL_RANDOM, 1'b1);
      end else if (sel <= 9) begin
        repeat ($urandom_range(1, 6)) send_byte(LINE_W'($urandom_range(0, 255)));
      end else if (sel <= 11) begin
        go_idle();
        wait_drained();
      end else begin
        sel = $urandom_range(0, 7);
        send_frame($urandom_range(0, 16),
                   (sel == 0) ? FILL_ONES : (sel == 1) ? FILL_ZEROS : FILL_RANDOM,
                   1'b0);
      end
    end

    go_idle();
    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
